/* sv/assert_macros.svh */
// ---------------------------------------------------------------------------
// assertion macros
// concurrent checks that compile away when synthesis is defined
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// checked on every edge outside reset
`define RPSG_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("rpsg assertion failed");
// checked on every edge, reset included
`define RPSG_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("rpsg assertion failed");
`else
`define RPSG_ASSERT(lbl, clk, rst_n, prop)
`define RPSG_ASSERT_RST(lbl, clk, prop)
`endif

`endif

/* sv/rpsg_pkg.sv */
// ---------------------------------------------------------------------------
// rpsg_pkg
// shared constants, codes and controller/datapath interface types
// ---------------------------------------------------------------------------
`default_nettype none

package rpsg_pkg;

    localparam int POINTS       = 16;
    localparam int NUM_PROFILES = 4;
    localparam int DEPTH        = NUM_PROFILES * POINTS;
    localparam int ADDR_W       = $clog2(DEPTH);

    localparam int TIME_W  = 12;
    localparam int TEMP_W  = 9;
    localparam int IDX_W   = 4;
    localparam int SEL_W   = 2;
    localparam int MS_W    = 32;
    localparam int PCT_W   = 7;
    localparam int SECS_W  = 23;
    localparam int WORD_W  = TIME_W + TEMP_W;

    localparam int DVD_W   = 32;
    localparam int DVS_W   = 16;

    localparam int MS_PER_S  = 1000;
    localparam int PCT_FULL  = 100;
    localparam int PCT_SCALE = MS_PER_S / PCT_FULL;
    localparam int TEMP_MAX  = 511;

    // ms to whole seconds: multiply by 2^38/1000 rounded up, exact for any 32-bit value
    localparam int                 RECIP_W     = 29;
    localparam int                 SECS_PROD_W = MS_W + RECIP_W;
    localparam int                 SECS_SHIFT  = 38;
    localparam logic [RECIP_W-1:0] SECS_RECIP  = 29'h1062_4DD3;

    typedef enum logic [1:0] {
        REQ_LOAD   = 2'd0,
        REQ_START  = 2'd1,
        REQ_MANUAL = 2'd2,
        REQ_TICK   = 2'd3
    } t_req;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_LOAD,
        OP_START,
        OP_MANUAL,
        OP_ELAPSED,
        OP_ADVANCE,
        OP_FINISH,
        OP_CAP_A,
        OP_CAP_B,
        OP_CAP_L,
        OP_CAP_SECS,
        OP_MUL,
        OP_HOLD,
        OP_INTERP,
        OP_PCT_FULL,
        OP_PCT,
        OP_OUT_LOAD
    } t_dp_op;

    typedef enum logic [1:0] {
        RD_SEG,
        RD_NEXT,
        RD_LAST
    } t_rd_sel;

    typedef enum logic [1:0] {
        DIV_INTERP,
        DIV_PCT
    } t_div_sel;

    typedef struct packed {
        t_dp_op   op;
        t_rd_sel  rd_sel;
        logic     div_start;
        t_div_sel div_sel;
    } t_cmd;

    typedef struct packed {
        t_req req;
        logic active;
        logic seg_end;
        logic times_equal;
        logic last_zero;
        logic div_busy;
        logic div_done;
    } t_status;

    function automatic logic [ADDR_W-1:0] slot(input logic [SEL_W-1:0] prof,
                                               input logic [IDX_W-1:0] idx);
        return ADDR_W'(prof) * ADDR_W'(POINTS) + ADDR_W'(idx);
    endfunction

endpackage

`default_nettype wire

/* sv/rpsg_divider.sv */
// ---------------------------------------------------------------------------
// rpsg_divider
// unsigned restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rpsg_divider (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [rpsg_pkg::DVD_W-1:0]  i_dividend,
    input  wire logic [rpsg_pkg::DVS_W-1:0]  i_divisor,
    output logic      [rpsg_pkg::DVD_W-1:0]  o_quotient,
    output logic                             o_busy,
    output logic                             o_done
);

    localparam int CNT_W = $clog2(rpsg_pkg::DVD_W);

    logic                        r_busy;
    logic                        r_done;
    logic [CNT_W-1:0]            r_cnt;
    logic [rpsg_pkg::DVD_W-1:0]  r_quo;
    logic [rpsg_pkg::DVS_W-1:0]  r_rem;
    logic [rpsg_pkg::DVS_W-1:0]  r_dvs;

    logic [rpsg_pkg::DVS_W:0]    trial;
    logic                        q_bit;
    logic [rpsg_pkg::DVS_W-1:0]  n_rem;

    always_comb begin
        trial = {r_rem, r_quo[rpsg_pkg::DVD_W-1]};
        q_bit = (trial >= {1'b0, r_dvs});
        n_rem = q_bit ? rpsg_pkg::DVS_W'(trial - {1'b0, r_dvs})
                      : trial[rpsg_pkg::DVS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(rpsg_pkg::DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[rpsg_pkg::DVD_W-2:0], q_bit};
            r_rem <= n_rem;
        end
    end

    assign o_quotient = r_quo;
    assign o_busy     = r_busy;
    assign o_done     = r_done;

    `RPSG_ASSERT(a_done_ends_busy, i_clk, i_rst_n, o_done |-> $past(o_busy))
    `RPSG_ASSERT(a_no_start_busy, i_clk, i_rst_n, i_start |-> !o_busy)
    `RPSG_ASSERT_RST(a_reset_clears, i_clk, !i_rst_n |=> (!o_busy && !o_done))

endmodule

`default_nettype wire

/* sv/rpsg_datapath.sv */
// ---------------------------------------------------------------------------
// rpsg_datapath
// point table, profile state, interpolation and progress arithmetic
// ---------------------------------------------------------------------------
`default_nettype none

module rpsg_datapath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire rpsg_pkg::t_cmd                i_cmd,
    output rpsg_pkg::t_status                  o_status,
    input  wire logic [1:0]                    i_req_type,
    input  wire logic [rpsg_pkg::SEL_W-1:0]    i_profile_sel,
    input  wire logic [rpsg_pkg::IDX_W-1:0]    i_point_index,
    input  wire logic [rpsg_pkg::TIME_W-1:0]   i_point_time_s,
    input  wire logic [rpsg_pkg::TEMP_W-1:0]   i_point_temp,
    input  wire logic [rpsg_pkg::MS_W-1:0]     i_now_ms,
    input  wire logic [rpsg_pkg::TEMP_W-1:0]   i_manual_target,
    output logic      [rpsg_pkg::TEMP_W-1:0]   o_target_temp,
    output logic                               o_running,
    output logic      [rpsg_pkg::IDX_W-1:0]    o_current_point,
    output logic      [rpsg_pkg::PCT_W-1:0]    o_progress_pct,
    output logic                               o_completed
);

    // latched request
    rpsg_pkg::t_req                  r_req;
    logic [rpsg_pkg::SEL_W-1:0]      r_sel;
    logic [rpsg_pkg::IDX_W-1:0]      r_pidx;
    logic [rpsg_pkg::TIME_W-1:0]     r_ptime;
    logic [rpsg_pkg::TEMP_W-1:0]     r_ptemp;
    logic [rpsg_pkg::MS_W-1:0]       r_now;
    logic [rpsg_pkg::TEMP_W-1:0]     r_manual;

    // profile state
    logic [rpsg_pkg::SEL_W-1:0]      r_prof;
    logic                            r_active;
    logic [rpsg_pkg::IDX_W-1:0]      r_seg;
    logic [rpsg_pkg::MS_W-1:0]       r_start;
    logic [rpsg_pkg::TEMP_W-1:0]     r_setpoint;

    // working registers
    logic [rpsg_pkg::MS_W-1:0]       r_e;
    logic [rpsg_pkg::TIME_W-1:0]     r_t0;
    logic [rpsg_pkg::TIME_W-1:0]     r_t1;
    logic [rpsg_pkg::TIME_W-1:0]     r_last;
    logic [rpsg_pkg::TEMP_W-1:0]     r_v0;
    logic [rpsg_pkg::TEMP_W-1:0]     r_v1;
    logic [rpsg_pkg::SECS_W-1:0]     r_secs;
    logic signed [33:0]              r_prod;
    logic signed [12:0]              r_den;
    logic [rpsg_pkg::DVS_W-1:0]      r_pct_div;
    logic [rpsg_pkg::PCT_W-1:0]      r_pct;
    logic                            r_done;
    logic [rpsg_pkg::IDX_W-1:0]      r_cur;

    // result register
    logic [rpsg_pkg::TEMP_W-1:0]     r_o_target;
    logic                            r_o_running;
    logic [rpsg_pkg::IDX_W-1:0]      r_o_cur;
    logic [rpsg_pkg::PCT_W-1:0]      r_o_pct;
    logic                            r_o_done;

    // point table
    logic [rpsg_pkg::WORD_W-1:0]     r_mem [rpsg_pkg::DEPTH];
    logic [rpsg_pkg::WORD_W-1:0]     r_rd;
    logic [rpsg_pkg::ADDR_W-1:0]     rd_addr;
    logic [rpsg_pkg::TIME_W-1:0]     rd_time;
    logic [rpsg_pkg::TEMP_W-1:0]     rd_temp;

    logic                            sel_ok;
    logic                            pidx_ok;
    logic                            seg_low;
    logic [rpsg_pkg::MS_W-1:0]       thr;
    logic [rpsg_pkg::SECS_PROD_W-1:0] secs_prod;
    logic signed [23:0]              diff;
    logic signed [9:0]               dv;
    logic signed [33:0]              prod_c;
    logic signed [12:0]              den_c;
    logic [33:0]                     prod_mag;
    logic [12:0]                     den_mag;
    logic                            q_neg;
    logic signed [33:0]              q_s;
    logic signed [33:0]              interp_sum;
    logic [rpsg_pkg::TEMP_W-1:0]     interp_sat;
    logic [rpsg_pkg::PCT_W-1:0]      pct_sat;

    logic [rpsg_pkg::DVD_W-1:0]      div_dvd;
    logic [rpsg_pkg::DVS_W-1:0]      div_dvs;
    logic [rpsg_pkg::DVD_W-1:0]      div_q;
    logic                            div_busy;
    logic                            div_done;

    always_comb begin
        sel_ok  = ({1'b0, r_sel} < 3'(rpsg_pkg::NUM_PROFILES));
        pidx_ok = ({1'b0, r_pidx} < 5'(rpsg_pkg::POINTS));
        seg_low = (r_seg < rpsg_pkg::IDX_W'(rpsg_pkg::POINTS - 2));

        case (i_cmd.rd_sel)
            rpsg_pkg::RD_NEXT: rd_addr = rpsg_pkg::slot(r_prof, r_seg + 4'd1);
            rpsg_pkg::RD_LAST:
                rd_addr = rpsg_pkg::slot(r_prof, rpsg_pkg::IDX_W'(rpsg_pkg::POINTS - 1));
            default:           rd_addr = rpsg_pkg::slot(r_prof, r_seg);
        endcase

        rd_time = r_rd[rpsg_pkg::TIME_W-1:0];
        rd_temp = r_rd[rpsg_pkg::WORD_W-1:rpsg_pkg::TIME_W];
        thr     = 32'(rd_time) * 32'(rpsg_pkg::MS_PER_S);

        secs_prod = rpsg_pkg::SECS_PROD_W'(r_e) * rpsg_pkg::SECS_PROD_W'(rpsg_pkg::SECS_RECIP);

        diff   = $signed({1'b0, r_secs}) - $signed({12'b0, r_t0});
        dv     = $signed({1'b0, r_v1}) - $signed({1'b0, r_v0});
        prod_c = diff * dv;
        den_c  = $signed({1'b0, r_t1}) - $signed({1'b0, r_t0});

        prod_mag = r_prod[33] ? 34'(-r_prod) : 34'(r_prod);
        den_mag  = r_den[12] ? 13'(-r_den) : 13'(r_den);
        q_neg    = r_prod[33] ^ r_den[12];
        q_s      = q_neg ? -$signed({2'b0, div_q}) : $signed({2'b0, div_q});
        interp_sum = q_s + $signed({25'b0, r_v0});
        if (interp_sum[33]) begin
            interp_sat = '0;
        end else if (interp_sum > 34'(rpsg_pkg::TEMP_MAX)) begin
            interp_sat = rpsg_pkg::TEMP_W'(rpsg_pkg::TEMP_MAX);
        end else begin
            interp_sat = interp_sum[rpsg_pkg::TEMP_W-1:0];
        end

        pct_sat = (div_q > 32'(rpsg_pkg::PCT_FULL)) ? rpsg_pkg::PCT_W'(rpsg_pkg::PCT_FULL)
                                                    : div_q[rpsg_pkg::PCT_W-1:0];

        case (i_cmd.div_sel)
            rpsg_pkg::DIV_PCT: begin
                div_dvd = r_e;
                div_dvs = r_pct_div;
            end
            default: begin
                div_dvd = prod_mag[rpsg_pkg::DVD_W-1:0];
                div_dvs = rpsg_pkg::DVS_W'(den_mag[11:0]);
            end
        endcase
    end

    rpsg_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_quotient (div_q),
        .o_busy     (div_busy),
        .o_done     (div_done)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == rpsg_pkg::OP_LOAD && sel_ok && pidx_ok) begin
            r_mem[rpsg_pkg::slot(r_sel, r_pidx)] <= {r_ptemp, r_ptime};
        end
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prof     <= '0;
            r_active   <= 1'b0;
            r_seg      <= '0;
            r_start    <= '0;
            r_setpoint <= '0;
        end else begin
            case (i_cmd.op)
                rpsg_pkg::OP_START: begin
                    if (sel_ok) begin
                        r_prof   <= r_sel;
                        r_active <= 1'b1;
                        r_seg    <= '0;
                        r_start  <= r_now;
                    end
                end
                rpsg_pkg::OP_MANUAL: begin
                    r_setpoint <= r_manual;
                    r_active   <= 1'b0;
                    r_seg      <= '0;
                    r_start    <= '0;
                end
                rpsg_pkg::OP_ADVANCE: begin
                    if (seg_low && r_e >= thr) begin
                        r_seg <= r_seg + 4'd1;
                    end
                end
                rpsg_pkg::OP_FINISH: begin
                    r_setpoint <= rd_temp;
                    r_active   <= 1'b0;
                    r_seg      <= '0;
                    r_start    <= '0;
                end
                rpsg_pkg::OP_HOLD:   r_setpoint <= r_v0;
                rpsg_pkg::OP_INTERP: r_setpoint <= interp_sat;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            rpsg_pkg::OP_LATCH: begin
                r_req    <= rpsg_pkg::t_req'(i_req_type);
                r_sel    <= i_profile_sel;
                r_pidx   <= i_point_index;
                r_ptime  <= i_point_time_s;
                r_ptemp  <= i_point_temp;
                r_now    <= i_now_ms;
                r_manual <= i_manual_target;
                r_pct    <= '0;
                r_done   <= 1'b0;
            end
            rpsg_pkg::OP_ELAPSED: r_e <= r_now - r_start;
            rpsg_pkg::OP_FINISH: begin
                r_done <= 1'b1;
                r_pct  <= rpsg_pkg::PCT_W'(rpsg_pkg::PCT_FULL);
                r_cur  <= r_seg;
            end
            rpsg_pkg::OP_CAP_A: begin
                r_t0 <= rd_time;
                r_v0 <= rd_temp;
            end
            rpsg_pkg::OP_CAP_B: begin
                r_t1 <= rd_time;
                r_v1 <= rd_temp;
            end
            rpsg_pkg::OP_CAP_L:    r_last <= rd_time;
            rpsg_pkg::OP_CAP_SECS: r_secs <= secs_prod[rpsg_pkg::SECS_SHIFT +: rpsg_pkg::SECS_W];
            rpsg_pkg::OP_MUL: begin
                r_prod    <= prod_c;
                r_den     <= den_c;
                r_pct_div <= rpsg_pkg::DVS_W'({4'b0, r_last} * 16'(rpsg_pkg::PCT_SCALE));
            end
            rpsg_pkg::OP_PCT_FULL: r_pct <= rpsg_pkg::PCT_W'(rpsg_pkg::PCT_FULL);
            rpsg_pkg::OP_PCT:      r_pct <= pct_sat;
            rpsg_pkg::OP_OUT_LOAD: begin
                r_o_target  <= r_setpoint;
                r_o_running <= r_active;
                r_o_cur     <= r_done ? r_cur : (r_active ? r_seg : '0);
                r_o_pct     <= r_pct;
                r_o_done    <= r_done;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_status.req         = r_req;
        o_status.active      = r_active;
        o_status.seg_end     = !seg_low;
        o_status.times_equal = (r_t0 == r_t1);
        o_status.last_zero   = (r_last == '0);
        o_status.div_busy    = div_busy;
        o_status.div_done    = div_done;
    end

    assign o_target_temp   = r_o_target;
    assign o_running       = r_o_running;
    assign o_current_point = r_o_cur;
    assign o_progress_pct  = r_o_pct;
    assign o_completed     = r_o_done;

endmodule

`default_nettype wire

/* sv/rpsg_ctrl.sv */
// ---------------------------------------------------------------------------
// rpsg_ctrl
// request sequencer driving the datapath and the result handshake
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rpsg_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_s_tvalid,
    output logic                    o_s_tready,
    output logic                    o_m_tvalid,
    input  wire logic               i_m_tready,
    output rpsg_pkg::t_cmd          o_cmd,
    input  wire rpsg_pkg::t_status  i_status
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_CHECK,
        S_BRANCH,
        S_FIN,
        S_CAP_A,
        S_CAP_B,
        S_CAP_L,
        S_SECS,
        S_MUL,
        S_INTERP_GO,
        S_INTERP,
        S_PCT_GO,
        S_PCT,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_m_valid;
    logic   n_m_valid;

    always_comb begin
        n_state         = r_state;
        n_m_valid       = r_m_valid;
        o_cmd.op        = rpsg_pkg::OP_NONE;
        o_cmd.rd_sel    = rpsg_pkg::RD_SEG;
        o_cmd.div_start = 1'b0;
        o_cmd.div_sel   = rpsg_pkg::DIV_INTERP;

        if (r_m_valid && i_m_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.op = rpsg_pkg::OP_LATCH;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_status.req)
                    rpsg_pkg::REQ_LOAD: begin
                        o_cmd.op = rpsg_pkg::OP_LOAD;
                        n_state  = S_OUT;
                    end
                    rpsg_pkg::REQ_START: begin
                        o_cmd.op = rpsg_pkg::OP_START;
                        n_state  = S_OUT;
                    end
                    rpsg_pkg::REQ_MANUAL: begin
                        o_cmd.op = rpsg_pkg::OP_MANUAL;
                        n_state  = S_OUT;
                    end
                    default: begin
                        if (i_status.active) begin
                            o_cmd.op     = rpsg_pkg::OP_ELAPSED;
                            o_cmd.rd_sel = rpsg_pkg::RD_NEXT;
                            n_state      = S_CHECK;
                        end else begin
                            n_state = S_OUT;
                        end
                    end
                endcase
            end
            S_CHECK: begin
                o_cmd.op = rpsg_pkg::OP_ADVANCE;
                n_state  = S_BRANCH;
            end
            S_BRANCH: begin
                o_cmd.rd_sel = rpsg_pkg::RD_SEG;
                n_state      = i_status.seg_end ? S_FIN : S_CAP_A;
            end
            S_FIN: begin
                o_cmd.op = rpsg_pkg::OP_FINISH;
                n_state  = S_OUT;
            end
            S_CAP_A: begin
                o_cmd.op     = rpsg_pkg::OP_CAP_A;
                o_cmd.rd_sel = rpsg_pkg::RD_NEXT;
                n_state      = S_CAP_B;
            end
            S_CAP_B: begin
                o_cmd.op     = rpsg_pkg::OP_CAP_B;
                o_cmd.rd_sel = rpsg_pkg::RD_LAST;
                n_state      = S_CAP_L;
            end
            S_CAP_L: begin
                o_cmd.op = rpsg_pkg::OP_CAP_L;
                n_state  = S_SECS;
            end
            S_SECS: begin
                o_cmd.op = rpsg_pkg::OP_CAP_SECS;
                n_state  = S_MUL;
            end
            S_MUL: begin
                o_cmd.op = rpsg_pkg::OP_MUL;
                n_state  = S_INTERP_GO;
            end
            S_INTERP_GO: begin
                if (i_status.times_equal) begin
                    o_cmd.op = rpsg_pkg::OP_HOLD;
                    n_state  = S_PCT_GO;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = rpsg_pkg::DIV_INTERP;
                    n_state         = S_INTERP;
                end
            end
            S_INTERP: begin
                o_cmd.div_sel = rpsg_pkg::DIV_INTERP;
                if (i_status.div_done) begin
                    o_cmd.op = rpsg_pkg::OP_INTERP;
                    n_state  = S_PCT_GO;
                end
            end
            S_PCT_GO: begin
                if (i_status.last_zero) begin
                    o_cmd.op = rpsg_pkg::OP_PCT_FULL;
                    n_state  = S_OUT;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = rpsg_pkg::DIV_PCT;
                    n_state         = S_PCT;
                end
            end
            S_PCT: begin
                o_cmd.div_sel = rpsg_pkg::DIV_PCT;
                if (i_status.div_done) begin
                    o_cmd.op = rpsg_pkg::OP_PCT;
                    n_state  = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_m_valid || i_m_tready) begin
                    o_cmd.op  = rpsg_pkg::OP_OUT_LOAD;
                    n_m_valid = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;

    `RPSG_ASSERT(a_div_start_free, i_clk, i_rst_n, o_cmd.div_start |-> !i_status.div_busy)
    `RPSG_ASSERT(a_accept_div_idle, i_clk, i_rst_n,
        (i_s_tvalid && o_s_tready) |-> !i_status.div_busy)
    `RPSG_ASSERT(a_valid_from_out, i_clk, i_rst_n, $rose(o_m_tvalid) |-> $past(r_state == S_OUT))

endmodule

`default_nettype wire

/* sv/reflow_profile_setpoint_generator.sv */
// ---------------------------------------------------------------------------
// reflow_profile_setpoint_generator
// piecewise linear reflow setpoint generator with a loadable point table
// ---------------------------------------------------------------------------
// channel   dir  fields (lowest bit first)
// s_axis    in   tuser: req_type; tdata: profile_sel, point_index, point_time_s,
//                point_temp, now_ms, manual_target (72 bits)
// m_axis    out  tdata: target_temp, running, current_point, progress_pct,
//                completed (24 bits)
//
// one request at a time; load, start, manual and idle ticks pass through decode
// and output only, a finishing tick also through check, branch and finish
// a running tick reads its segment and then makes two passes of the
// one-bit-per-cycle divider (interpolation, progress); equal point times
// or a zero last time skip a pass
// point table is undefined after reset, no clearing pass
// a new request is taken while the previous result waits; only the final
// result write stalls on m_axis_tready
// ---------------------------------------------------------------------------
`default_nettype none

module reflow_profile_setpoint_generator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,  // profile_sel, point_index, point_time_s,
                                            // point_temp, now_ms, manual_target
    input  wire logic [1:0]  s_axis_tuser,  // req_type
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata   // target_temp, running, current_point,
                                            // progress_pct, completed
);

    rpsg_pkg::t_cmd    cmd;
    rpsg_pkg::t_status status;

    logic [rpsg_pkg::TEMP_W-1:0] target_temp;
    logic                        running;
    logic [rpsg_pkg::IDX_W-1:0]  current_point;
    logic [rpsg_pkg::PCT_W-1:0]  progress_pct;
    logic                        completed;

    rpsg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    rpsg_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_req_type      (s_axis_tuser),
        .i_profile_sel   (s_axis_tdata[1:0]),
        .i_point_index   (s_axis_tdata[5:2]),
        .i_point_time_s  (s_axis_tdata[17:6]),
        .i_point_temp    (s_axis_tdata[26:18]),
        .i_now_ms        (s_axis_tdata[58:27]),
        .i_manual_target (s_axis_tdata[67:59]),
        .o_target_temp   (target_temp),
        .o_running       (running),
        .o_current_point (current_point),
        .o_progress_pct  (progress_pct),
        .o_completed     (completed)
    );

    assign m_axis_tdata = {2'b00, completed, progress_pct, current_point, running, target_temp};

endmodule

`default_nettype wire
